// File: design/ncs_pkg.sv
// Shared types and constants for the NAND command cycle sequencer.
`default_nettype none

package ncs_pkg;

    // bus cycle kinds
    localparam logic [1:0] KIND_CMD   = 2'd0;
    localparam logic [1:0] KIND_ADDR  = 2'd1;
    localparam logic [1:0] KIND_DELAY = 2'd2;
    localparam logic [1:0] KIND_POLL  = 2'd3;

    // NAND command bytes
    localparam logic [7:0] OP_READ0       = 8'h00;
    localparam logic [7:0] OP_RNDOUT      = 8'h05;
    localparam logic [7:0] OP_PAGEPROG    = 8'h10;
    localparam logic [7:0] OP_CACHEDPROG  = 8'h15;
    localparam logic [7:0] OP_READSTART   = 8'h30;
    localparam logic [7:0] OP_READOOB     = 8'h50;
    localparam logic [7:0] OP_ERASE1      = 8'h60;
    localparam logic [7:0] OP_STATUS      = 8'h70;
    localparam logic [7:0] OP_SEQIN       = 8'h80;
    localparam logic [7:0] OP_RNDIN       = 8'h85;
    localparam logic [7:0] OP_REPEAT      = 8'h99;
    localparam logic [7:0] OP_ERASE2      = 8'hD0;
    localparam logic [7:0] OP_RNDOUTSTART = 8'hE0;
    localparam logic [7:0] OP_RESET       = 8'hFF;

    // configuration register indexes
    localparam logic [1:0] REG_PAGE_SIZE     = 2'd0;
    localparam logic [1:0] REG_DELAY_TIME    = 2'd1;
    localparam logic [1:0] REG_HAS_READY_PIN = 2'd2;

    localparam logic [12:0] PAGE_SIZE_RESET  = 13'd2048;
    localparam logic [7:0]  DELAY_TIME_RESET = 8'd5;

    // slots of a request's cycle list, emitted in ascending order
    localparam int unsigned NUM_SLOTS = 11;
    localparam logic [3:0] SLOT_CMD      = 4'd0;
    localparam logic [3:0] SLOT_COL_LO   = 4'd1;
    localparam logic [3:0] SLOT_COL_HI   = 4'd2;
    localparam logic [3:0] SLOT_PAGE_0   = 4'd3;
    localparam logic [3:0] SLOT_PAGE_1   = 4'd4;
    localparam logic [3:0] SLOT_PAGE_2   = 4'd5;
    localparam logic [3:0] SLOT_START    = 4'd6;
    localparam logic [3:0] SLOT_DELAY    = 4'd7;
    localparam logic [3:0] SLOT_STATUS   = 4'd8;
    localparam logic [3:0] SLOT_POLL     = 4'd9;
    localparam logic [3:0] SLOT_REREAD   = 4'd10;

    localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

    typedef struct packed {
        logic [12:0] page_size;
        logic [7:0]  delay_time;
        logic        has_ready_pin;
    } cfg_t;

    // one classified request
    typedef struct packed {
        logic [NUM_SLOTS-1:0] slot_mask;
        logic [7:0]           command;
        logic [12:0]          half_column;
        logic [23:0]          page;
        logic [7:0]           delay_time;
        logic                 start_is_read;
    } desc_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

endpackage

`default_nettype wire

// File: design/nand_command_cycle_sequencer.sv
// Top level of the NAND command cycle sequencer: configuration registers and block wiring.
//
// Turns one large-page NAND request into its bus cycle words (command latch, address
// latch, delay, status poll), one word per clock on the output channel while out_stall
// is low. A request yields 1 command word, up to 2 column and 3 page words, and tail
// words, from 1 to 11 in all; the cycle generator, emitting one word a clock, sets that rate.
// An accepted request is first written into the queue; its first word is then captured
// in the output register. The front end translates read-OOB and repeat-read and places
// the request in a queue of QUEUE_DEPTH requests, so new requests are taken while
// earlier ones are still being emitted. Configuration registers are written through
// the cfg channel, which is always ready; write them only while the block is idle.
`default_nettype none

module nand_command_cycle_sequencer
    import ncs_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [12:0] cfg_data,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  command,
    input  wire logic        column_valid,
    input  wire logic [12:0] column,
    input  wire logic        page_valid,
    input  wire logic [23:0] page,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       cycle_kind,
    output logic [7:0]       cycle_value,
    output logic             last_cycle
);

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    logic    push;
    desc_t   push_desc;
    logic    pop;
    desc_t   head;
    q_stat_t q_stat;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_PAGE_SIZE:     cfg_next.page_size     = cfg_data;
                REG_DELAY_TIME:    cfg_next.delay_time    = cfg_data[7:0];
                REG_HAS_READY_PIN: cfg_next.has_ready_pin = cfg_data[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.page_size     <= PAGE_SIZE_RESET;
            cfg_reg.delay_time    <= DELAY_TIME_RESET;
            cfg_reg.has_ready_pin <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ncs_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (in_valid),
        .command      (command),
        .column_valid (column_valid),
        .column       (column),
        .page_valid   (page_valid),
        .page         (page),
        .q_stat       (q_stat),
        .in_stall     (in_stall),
        .push         (push),
        .push_desc    (push_desc)
    );

    ncs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    ncs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_stat      (q_stat),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cycle_kind  (cycle_kind),
        .cycle_value (cycle_value),
        .last_cycle  (last_cycle)
    );

    // never write a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("request pushed into a full queue");

    // only retire a request that is present
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("request retired from an empty queue");

    // a poll word always carries zero
    a_poll_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && cycle_kind == KIND_POLL) |-> (cycle_value == 8'h00))
        else $error("poll word with non-zero value");

    // a retired request leaves its final word in the output register
    a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (out_valid && last_cycle))
        else $error("request retired without a final word");

endmodule

`default_nettype wire

// File: design/ncs_front.sv
// Front end: accepts requests, translates commands and builds the cycle-slot descriptor.
`default_nettype none

module ncs_front
    import ncs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    input  wire logic        in_valid,
    input  wire logic [7:0]  command,
    input  wire logic        column_valid,
    input  wire logic [12:0] column,
    input  wire logic        page_valid,
    input  wire logic [23:0] page,
    input  wire q_stat_t     q_stat,
    output logic             in_stall,
    output logic             push,
    output desc_t            push_desc
);

    logic [23:0] saved_page_reg;
    logic [23:0] saved_page_next;
    logic        saved_valid_reg;
    logic        saved_valid_next;

    logic        is_oob;
    logic [7:0]  cmd_a;
    logic [7:0]  cmd_b;
    logic [13:0] col_sum;
    logic [13:0] col_minus;
    logic [13:0] col_full;
    logic        col_ok;
    logic [23:0] pg;
    logic        pg_ok;
    logic        is_read0;
    logic [NUM_SLOTS-1:0] mask;

    assign in_stall = q_stat.full;
    assign push     = in_valid && !q_stat.full;

    always_comb
    begin
        is_oob    = (command == OP_READOOB);
        col_sum   = {1'b0, column} + {1'b0, cfg.page_size};
        col_minus = {1'b0, cfg.page_size} - 14'd1;
        if (is_oob)
        begin
            col_full = column_valid ? col_sum : col_minus;
            col_ok   = 1'b1;
            cmd_a    = OP_READ0;
        end
        else
        begin
            col_full = {1'b0, column};
            col_ok   = column_valid;
            cmd_a    = command;
        end

        // repeat reuses the page of the last read
        if (cmd_a == OP_REPEAT)
        begin
            cmd_b = OP_READ0;
            pg    = saved_page_reg;
            pg_ok = saved_valid_reg;
        end
        else
        begin
            cmd_b = cmd_a;
            pg    = page;
            pg_ok = page_valid;
        end
        is_read0 = (cmd_b == OP_READ0);

        mask = '0;
        mask[SLOT_CMD]    = 1'b1;
        mask[SLOT_COL_LO] = col_ok;
        mask[SLOT_COL_HI] = col_ok;
        mask[SLOT_PAGE_0] = pg_ok;
        mask[SLOT_PAGE_1] = pg_ok;
        mask[SLOT_PAGE_2] = pg_ok;
        case (cmd_b)
            OP_READ0:
            begin
                mask[SLOT_START]  = 1'b1;
                mask[SLOT_DELAY]  = 1'b1;
                mask[SLOT_STATUS] = 1'b1;
                mask[SLOT_POLL]   = 1'b1;
                mask[SLOT_REREAD] = 1'b1;
            end
            OP_RNDOUT:
            begin
                mask[SLOT_START] = 1'b1;
            end
            OP_CACHEDPROG, OP_PAGEPROG, OP_ERASE1, OP_ERASE2,
            OP_SEQIN, OP_RNDIN, OP_STATUS:
            begin
                mask[SLOT_START] = 1'b0;
            end
            OP_RESET:
            begin
                mask[SLOT_DELAY]  = !cfg.has_ready_pin;
                mask[SLOT_STATUS] = !cfg.has_ready_pin;
                mask[SLOT_POLL]   = !cfg.has_ready_pin;
            end
            default:
            begin
                mask[SLOT_DELAY] = !cfg.has_ready_pin;
            end
        endcase

        push_desc.slot_mask     = mask;
        push_desc.command       = cmd_b;
        push_desc.half_column   = col_full[13:1];
        push_desc.page          = pg;
        push_desc.delay_time    = cfg.delay_time;
        push_desc.start_is_read = is_read0;

        saved_page_next  = saved_page_reg;
        saved_valid_next = saved_valid_reg;
        if (push && is_read0)
        begin
            saved_page_next  = pg;
            saved_valid_next = pg_ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            saved_page_reg  <= '0;
            saved_valid_reg <= 1'b0;
        end
        else
        begin
            saved_page_reg  <= saved_page_next;
            saved_valid_reg <= saved_valid_next;
        end
    end

endmodule

`default_nettype wire

// File: design/ncs_queue.sv
// Short request queue between the front end and the cycle generator.
`default_nettype none

module ncs_queue
    import ncs_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire desc_t push_desc,
    input  wire logic  pop,
    output desc_t      head,
    output q_stat_t    q_stat
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    desc_t            entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign head         = entry_reg[rd_ptr_reg];
    assign q_stat.empty = (count_reg == '0);
    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

`default_nettype wire

// File: design/ncs_back.sv
// Back end: walks the head request's slots and emits one bus cycle word per clock while not stalled.
`default_nettype none

module ncs_back
    import ncs_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire desc_t   head,
    input  wire q_stat_t q_stat,
    output logic         pop,
    output logic         out_valid,
    input  wire logic    out_stall,
    output logic [1:0]   cycle_kind,
    output logic [7:0]   cycle_value,
    output logic         last_cycle
);

    logic [NUM_SLOTS-1:0] done_reg;
    logic [NUM_SLOTS-1:0] done_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [1:0]           kind_reg;
    logic [7:0]           value_reg;
    logic                 last_reg;

    logic [NUM_SLOTS-1:0] remaining;
    logic [NUM_SLOTS-1:0] sel;
    logic [3:0]           slot;
    logic                 is_last;
    logic                 advance;
    logic                 emit;
    logic [1:0]           kind;
    logic [7:0]           value;

    assign out_valid   = out_valid_reg;
    assign cycle_kind  = kind_reg;
    assign cycle_value = value_reg;
    assign last_cycle  = last_reg;

    always_comb
    begin
        remaining = head.slot_mask & ~done_reg;
        // isolate the lowest pending slot
        sel       = remaining & (~remaining + NUM_SLOTS'(1));
        slot      = SLOT_CMD;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (sel[i])
            begin
                slot = 4'(i);
            end
        end
        is_last = ((remaining & ~sel) == '0);
        advance = !out_valid_reg || !out_stall;
        emit    = !q_stat.empty && advance;
        pop     = emit && is_last;

        case (slot)
            SLOT_CMD:    begin kind = KIND_CMD;   value = head.command;                   end
            SLOT_COL_LO: begin kind = KIND_ADDR;  value = head.half_column[7:0];          end
            SLOT_COL_HI: begin kind = KIND_ADDR;  value = {3'b000, head.half_column[12:8]}; end
            SLOT_PAGE_0: begin kind = KIND_ADDR;  value = head.page[7:0];                 end
            SLOT_PAGE_1: begin kind = KIND_ADDR;  value = head.page[15:8];                end
            SLOT_PAGE_2: begin kind = KIND_ADDR;  value = head.page[23:16];               end
            SLOT_START:
            begin
                kind  = KIND_CMD;
                value = head.start_is_read ? OP_READSTART : OP_RNDOUTSTART;
            end
            SLOT_DELAY:  begin kind = KIND_DELAY; value = head.delay_time;                end
            SLOT_STATUS: begin kind = KIND_CMD;   value = OP_STATUS;                      end
            SLOT_POLL:   begin kind = KIND_POLL;  value = 8'h00;                          end
            SLOT_REREAD: begin kind = KIND_CMD;   value = OP_READ0;                       end
            default:     begin kind = KIND_CMD;   value = 8'h00;                          end
        endcase

        done_next      = done_reg;
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            done_next      = is_last ? '0 : (done_reg | sel);
        end
        else if (advance)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the word while stalled
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg  <= kind;
            value_reg <= value;
            last_reg  <= is_last;
        end
    end

endmodule

`default_nettype wire
